FILE: src/sird_pkg.sv
// ----------------------------------------------------------------------------
// sird_pkg: shared types and constants
// Widths, codes and types used by the integer-to-digits converter modules.
// ----------------------------------------------------------------------------
package sird_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int MAX_RADIX   = 16;
  localparam int RADIX_W     = 5;
  localparam int DIGIT_W     = 4;
  localparam int CHAR_W      = 8;
  localparam int SYM_W       = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int STEP_BITS   = 8;
  localparam int STEPS       = VALUE_BITS / STEP_BITS;
  localparam int STEP_CNT_W  = $clog2(STEPS);
  localparam int STACK_DEPTH = VALUE_BITS;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [CHAR_W-1:0] MINUS_CODE = 8'h2D;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [SYM_W-1:0]   SYMBOLS_LOW_RESET  = 64'h3736353433323130;
  localparam logic [SYM_W-1:0]   SYMBOLS_HIGH_RESET = 64'h4645444342413938;

  typedef logic [RADIX_W-1:0] base_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [CNT_W-1:0]   count_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    digit_t digit;
  } stack_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SIGN,
    ST_EMIT
  } state_t;

endpackage

FILE: src/sird_div_step.sv
// ----------------------------------------------------------------------------
// sird_div_step: shared divider slice
// Eight restoring compare-subtract steps of a division by the base.
// ----------------------------------------------------------------------------
module sird_div_step (
  input  sird_pkg::digit_t                     rem_in,
  input  logic [sird_pkg::STEP_BITS-1:0]       bits_in,
  input  sird_pkg::base_t                      base,
  output logic [sird_pkg::STEP_BITS-1:0]       quot,
  output sird_pkg::digit_t                     rem_out
);
  import sird_pkg::*;

  always_comb begin
    logic [DIGIT_W-1:0] r;
    logic [DIGIT_W:0]   t;
    r = rem_in;
    quot = '0;
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      t = {r, bits_in[i]};
      if (t >= base) begin
        quot[i] = 1'b1;
        r = DIGIT_W'(t - base);
      end else begin
        r = t[DIGIT_W-1:0];
      end
    end
    rem_out = r;
  end

endmodule

FILE: src/sird_digit_stack.sv
// ----------------------------------------------------------------------------
// sird_digit_stack: digit LIFO
// Shift-register stack that reverses digits from least to most significant.
// ----------------------------------------------------------------------------
module sird_digit_stack (
  input  logic                 clk,
  input  logic                 rst,
  input  sird_pkg::stack_ctl_t ctl,
  output sird_pkg::digit_t     top,
  output sird_pkg::count_t     count
);
  import sird_pkg::*;

  digit_t entry [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      entry[0] <= ctl.digit;
      for (int i = 1; i < STACK_DEPTH; i++) begin
        entry[i] <= entry[i-1];
      end
    end else if (ctl.pop) begin
      for (int i = 0; i < STACK_DEPTH - 1; i++) begin
        entry[i] <= entry[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.push) begin
      count <= count + 1'b1;
    end else if (ctl.pop) begin
      count <= count - 1'b1;
    end
  end

  assign top = entry[0];

endmodule

FILE: src/signed_int_to_radix_digits.sv
// ----------------------------------------------------------------------------
// signed_int_to_radix_digits: signed integer to text in a configurable base
// Each digit takes four passes of a shared eight-bit divider slice.
// A new number is taken only in the idle state, once every character of the
// previous one has gone to the output register.
// Reset clears the control state and sets base 10 with alphabet 0-9A-F.
// ----------------------------------------------------------------------------
module signed_int_to_radix_digits (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [sird_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sird_pkg::SYM_W-1:0]            cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [sird_pkg::VALUE_BITS-1:0] value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [sird_pkg::CHAR_W-1:0]           character,
  output logic                                  last
);
  import sird_pkg::*;

  logic [RADIX_W-1:0] radix;
  logic [SYM_W-1:0]   symbols_low;
  logic [SYM_W-1:0]   symbols_high;

  state_t                 state, state_next;
  logic [VALUE_BITS-1:0]  mag, mag_next;
  digit_t                 rem, rem_next;
  logic [STEP_CNT_W-1:0]  step, step_next;
  logic                   neg, neg_next;
  base_t                  base, base_next;
  logic                   out_valid_next;
  logic [CHAR_W-1:0]      character_next;
  logic                   last_next;

  logic [STEP_BITS-1:0]   quot;
  digit_t                 rem_step;
  logic [VALUE_BITS-1:0]  mag_shift;
  stack_ctl_t             stack_ctl;
  digit_t                 stack_top;
  count_t                 stack_count;
  base_t                  eff_radix;
  logic [VALUE_BITS-1:0]  value_u;
  logic [SYM_W-1:0]       sym_word;
  logic                   slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix        <= RADIX_RESET;
      symbols_low  <= SYMBOLS_LOW_RESET;
      symbols_high <= SYMBOLS_HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIX:        radix        <= cfg_data[RADIX_W-1:0];
        REG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
        REG_SYMBOLS_HIGH: symbols_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (radix < base_t'(2)) begin
      eff_radix = base_t'(2);
    end else if (radix > base_t'(MAX_RADIX)) begin
      eff_radix = base_t'(MAX_RADIX);
    end else begin
      eff_radix = radix;
    end
  end

  sird_div_step u_div_step (
    .rem_in  (rem),
    .bits_in (mag[VALUE_BITS-1 -: STEP_BITS]),
    .base    (base),
    .quot    (quot),
    .rem_out (rem_step)
  );

  sird_digit_stack u_digit_stack (
    .clk   (clk),
    .rst   (rst),
    .ctl   (stack_ctl),
    .top   (stack_top),
    .count (stack_count)
  );

  assign value_u   = value;
  assign mag_shift = {mag[VALUE_BITS-STEP_BITS-1:0], quot};
  assign sym_word  = stack_top[DIGIT_W-1] ? symbols_high : symbols_low;
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    mag       <= mag_next;
    rem       <= rem_next;
    step      <= step_next;
    neg       <= neg_next;
    base      <= base_next;
    character <= character_next;
    last      <= last_next;
  end

  always_comb begin
    state_next     = state;
    mag_next       = mag;
    rem_next       = rem;
    step_next      = step;
    neg_next       = neg;
    base_next      = base;
    out_valid_next = out_valid && !out_ready;
    character_next = character;
    last_next      = last;
    stack_ctl      = '{push: 1'b0, pop: 1'b0, digit: rem_step};

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          neg_next   = value_u[VALUE_BITS-1];
          mag_next   = value_u[VALUE_BITS-1] ? (VALUE_BITS'(0) - value_u) : value_u;
          rem_next   = '0;
          step_next  = '0;
          base_next  = eff_radix;
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        mag_next  = mag_shift;
        rem_next  = rem_step;
        step_next = step + 1'b1;
        if (step == STEP_CNT_W'(STEPS - 1)) begin
          stack_ctl.push = 1'b1;
          rem_next       = '0;
          if (mag_shift == '0) begin
            state_next = neg ? ST_SIGN : ST_EMIT;
          end
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          character_next = MINUS_CODE;
          last_next      = 1'b0;
          state_next     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          character_next = sym_word[stack_top[DIGIT_W-2:0]*CHAR_W +: CHAR_W];
          last_next      = (stack_count == count_t'(1));
          stack_ctl.pop  = 1'b1;
          if (stack_count == count_t'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/sird_checker.sv
// ----------------------------------------------------------------------------
// sird_checker: port-level checks for the converter
// Watches the handshakes and framing of the top level and is bound to it.
// ----------------------------------------------------------------------------
module sird_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [sird_pkg::CHAR_W-1:0]   character,
  input logic                          last
);
  import sird_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last))
    else $error("stalled output changed");

  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  a_mid_number_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |-> !in_ready)
    else $error("input ready before the number was finished");

  a_idle_only_last: assert property (@(posedge clk) disable iff (rst)
    in_ready && out_valid |-> last)
    else $error("input ready while a non-final character waits");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind signed_int_to_radix_digits sird_checker u_sird_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .character (character),
  .last      (last)
);

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for signed_int_to_radix_digits
// Sends signed integers under several bases and alphabets and checks every
// character and its last flag against literal table text or a behavioral model.
// A directed table covers extremes and corner settings, then random phases.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sird_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 40;

  typedef enum logic {ROW_WRITE, ROW_VALUE} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   index;
    logic [SYM_W-1:0]       data;
    logic [VALUE_BITS-1:0]  number;
    logic [127:0]           text;
  } row_t;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              tail;
  } glyph_t;

  localparam int ROWS = 35;

  row_t plan [ROWS] = '{
    '{ROW_VALUE, REG_RADIX, '0, 32'd0, "0"},
    '{ROW_VALUE, REG_RADIX, '0, 32'd10, "10"},
    '{ROW_VALUE, REG_RADIX, '0, 32'd9, "9"},
    '{ROW_VALUE, REG_RADIX, '0, 32'hFFFF_FFFF, "-1"},
    '{ROW_VALUE, REG_RADIX, '0, 32'h7FFF_FFFF, "2147483647"},
    '{ROW_VALUE, REG_RADIX, '0, 32'h8000_0000, "-2147483648"},
    '{ROW_VALUE, REG_RADIX, '0, 32'd1000000000, "1000000000"},
    '{ROW_VALUE, REG_RADIX, '0, 32'hFFFF_FFF6, "-10"},
    '{ROW_WRITE, REG_RADIX, 64'hFFFF_FFFF_FFFF_FFF0, '0, '0},
    '{ROW_VALUE, REG_RADIX, '0, 32'h8000_0000, "-80000000"},
    '{ROW_VALUE, REG_RADIX, '0, 32'h7FFF_FFFF, "7FFFFFFF"},
    '{ROW_VALUE, REG_RADIX, '0, 32'hFFFF_FF00, "-100"},
    '{ROW_VALUE, REG_RADIX, '0, 32'h0000_ABCD, "ABCD"},
    '{ROW_WRITE, REG_RADIX, 64'd2, '0, '0},
    '{ROW_VALUE, REG_RADIX, '0, 32'h8000_0000, '0},
    '{ROW_VALUE, REG_RADIX, '0, 32'h7FFF_FFFF, '0},
    '{ROW_VALUE, REG_RADIX, '0, 32'd5, "101"},
    '{ROW_WRITE, REG_RADIX, 64'd0, '0, '0},
    '{ROW_VALUE, REG_RADIX, '0, 32'd6, "110"},
    '{ROW_WRITE, REG_RADIX, 64'd1, '0, '0},
    '{ROW_VALUE, REG_RADIX, '0, 32'hFFFF_FFFD, "-11"},
    '{ROW_WRITE, REG_RADIX, 64'd31, '0, '0},
    '{ROW_VALUE, REG_RADIX, '0, 32'd255, "FF"},
    '{ROW_WRITE, REG_RADIX, 64'd17, '0, '0},
    '{ROW_VALUE, REG_RADIX, '0, 32'd4096, "1000"},
    '{ROW_WRITE, REG_SYMBOLS_LOW, 64'h6161_6161_6161_6161, '0, '0},
    '{ROW_WRITE, REG_SYMBOLS_HIGH, 64'h7A7A_7A7A_7A7A_7A7A, '0, '0},
    '{ROW_VALUE, REG_RADIX, '0, 32'h1234_5678, "aaaaaaaz"},
    '{ROW_WRITE, REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0},
    '{ROW_VALUE, REG_RADIX, '0, 32'd0, "a"},
    '{ROW_WRITE, REG_SYMBOLS_LOW, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0},
    '{ROW_WRITE, REG_SYMBOLS_HIGH, 64'd0, '0, '0},
    '{ROW_VALUE, REG_RADIX, '0, 32'h89AB_CDEF, '0},
    '{ROW_VALUE, REG_RADIX, '0, 32'h0F0F_0F0F, '0},
    '{ROW_VALUE, REG_RADIX, '0, 32'd7, '0}
  };

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [SYM_W-1:0]             cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic signed [VALUE_BITS-1:0] value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [CHAR_W-1:0]            character;
  logic                         last;

  logic [RADIX_W-1:0] radix_m = RADIX_RESET;
  logic [SYM_W-1:0]   sym_low_m = SYMBOLS_LOW_RESET;
  logic [SYM_W-1:0]   sym_high_m = SYMBOLS_HIGH_RESET;

  glyph_t due_chars[$];
  int     numbers_sent = 0;
  int     chars_checked = 0;
  int     mismatches = 0;
  int     cycles = 0;
  bit     quiet = 1'b0;
  bit     hold_req = 1'b0;
  bit     hold_done = 1'b0;
  int     hold_left = 0;
  int     stall_left = 0;

  signed_int_to_radix_digits uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .last      (last)
  );

  always #5 clk = ~clk;

  function automatic int unsigned conv_base();
    int unsigned b;
    b = radix_m;
    if (b < 2) b = 2;
    if (b > MAX_RADIX) b = MAX_RADIX;
    return b;
  endfunction

  function automatic logic [CHAR_W-1:0] glyph_of(input digit_t d);
    logic [SYM_W-1:0] word;
    word = d[3] ? sym_high_m : sym_low_m;
    return word[d[2:0]*8 +: 8];
  endfunction

  task automatic spell_number(input logic [VALUE_BITS-1:0] v);
    logic [VALUE_BITS-1:0] mag;
    int unsigned base;
    digit_t digs[$];
    int k;
    base = conv_base();
    mag = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
    do begin
      digs.push_front(digit_t'(mag % base));
      mag = mag / base;
    end while (mag != 0);
    if (v[VALUE_BITS-1]) due_chars.push_back('{MINUS_CODE, 1'b0});
    for (k = 0; k < digs.size(); k++)
      due_chars.push_back('{glyph_of(digs[k]), k == digs.size() - 1});
  endtask

  task automatic spell_literal(input logic [127:0] text);
    int n;
    int i;
    n = 16;
    while (n > 0 && text[(n-1)*8 +: 8] == 8'd0) n--;
    for (i = n - 1; i >= 0; i--) due_chars.push_back('{text[i*8 +: 8], i == 0});
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_value(input int unsigned base);
    logic [63:0] p;
    logic [VALUE_BITS-1:0] r;
    int unsigned k;
    int unsigned i;
    case ($urandom_range(0, 7))
      0, 1, 2: r = $urandom;
      3: r = $urandom_range(0, 600) - 300;
      4, 5: begin
        p = 1;
        k = $urandom_range(0, 31);
        for (i = 0; i < k && p * base <= 64'h8000_0000; i++) p = p * base;
        if ($urandom_range(0, 1)) p = p - 1;
        r = p[VALUE_BITS-1:0];
        if ($urandom_range(0, 1)) r = ~r + 1'b1;
      end
      6: begin
        case ($urandom_range(0, 4))
          0: r = '0;
          1: r = '1;
          2: r = 32'h7FFF_FFFF;
          3: r = 32'h8000_0000;
          default: r = 32'd1;
        endcase
      end
      default: begin
        r = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) r = ~r + 1'b1;
      end
    endcase
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SYM_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_RADIX:        radix_m = data[RADIX_W-1:0];
      REG_SYMBOLS_LOW:  sym_low_m = data;
      REG_SYMBOLS_HIGH: sym_high_m = data;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_chars.size() != 0) @(negedge clk);
    while (!in_ready) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic send_value(input logic [VALUE_BITS-1:0] v, input logic [127:0] text);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    do @(posedge clk); while (!in_ready);
    if (text == '0) spell_number(v);
    else spell_literal(text);
    numbers_sent++;
  endtask

  // Receiver side: random stalls plus one long hold-off that backs up the block.
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 11);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    glyph_t exp_c;
    if (!rst && out_valid && out_ready) begin
      chars_checked++;
      if (due_chars.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected character %h last %b", $time, character, last);
      end else begin
        exp_c = due_chars.pop_front();
        if (character !== exp_c.code) begin
          mismatches++;
          $display("%0t: character mismatch, expected %h, got %h", $time, exp_c.code,
                   character);
        end
        if (last !== exp_c.tail) begin
          mismatches++;
          $display("%0t: last mismatch, expected %b, got %b", $time, exp_c.tail, last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d characters outstanding.", cycles,
               due_chars.size());
      $display("[signed_int_to_radix_digits] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int r;
    int phase;
    int n;
    logic [SYM_W-1:0] radix_word;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (r = 0; r < ROWS; r++) begin
      if (plan[r].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(plan[r].index, plan[r].data);
      end else begin
        send_value(plan[r].number, plan[r].text);
      end
    end

    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      radix_word = {$urandom, $urandom};
      case (phase)
        0: radix_word[RADIX_W-1:0] = 5'd10;
        1: radix_word[RADIX_W-1:0] = 5'd2;
        2: radix_word[RADIX_W-1:0] = 5'd16;
        3: radix_word[RADIX_W-1:0] = 5'd3;
        default: radix_word[RADIX_W-1:0] = $urandom_range(0, 31);
      endcase
      write_reg(REG_RADIX, radix_word);
      if (phase == 0) begin
        write_reg(REG_SYMBOLS_LOW, SYMBOLS_LOW_RESET);
        write_reg(REG_SYMBOLS_HIGH, SYMBOLS_HIGH_RESET);
      end else begin
        write_reg(REG_SYMBOLS_LOW, {$urandom, $urandom});
        write_reg(REG_SYMBOLS_HIGH, {$urandom, $urandom});
      end
      if (phase == 2) hold_req = 1'b1;
      if (phase == PHASES - 1) quiet = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) send_value(pick_value(conv_base()), '0);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (due_chars.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Converted %0d numbers into %0d characters across %0d random settings.",
             numbers_sent, chars_checked, PHASES);
    $display("Directed table covered bases 2, 10, 16, clamped radix values and odd alphabets.");
    if (mismatches == 0 && due_chars.size() == 0) begin
      $display("[signed_int_to_radix_digits] OK");
    end else begin
      $display("[signed_int_to_radix_digits] ERROR");
    end
    $finish;
  end

endmodule
